>>> src/dswap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dswap_pkg
// Shared types, constants, microcode table and helpers for the descriptor
// driven byte-order swapper.
// ----------------------------------------------------------------------------
package dswap_pkg;

  localparam int DESC_BYTES = 16;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_DESC_LOW  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_DESC_HIGH = 1'b1;

  // Record status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_SIZE = 2'd1;
  localparam logic [1:0] STATUS_LEN_ERR  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } dswap_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] status;
  } dswap_out_t;

  // Micro-operations executed by the datapath.
  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_ADVANCE,
    UOP_ACCEPT,
    UOP_SCAN,
    UOP_TAIL,
    UOP_EMIT,
    UOP_CLOSE
  } uop_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_ADV_BUSY,
    COND_NO_XFER,
    COND_NOT_LAST,
    COND_SCAN_BUSY,
    COND_EMIT_BUSY
  } cond_t;

  typedef logic [2:0] step_t;

  localparam step_t STEP_ADVANCE = 3'd0;
  localparam step_t STEP_ACCEPT  = 3'd1;
  localparam step_t STEP_CHECK   = 3'd2;
  localparam step_t STEP_SCAN    = 3'd3;
  localparam step_t STEP_TAIL    = 3'd4;
  localparam step_t STEP_EMIT    = 3'd5;
  localparam step_t STEP_CLOSE   = 3'd6;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    step_t target;
  } ucode_word_t;

  // Status bits that the sequencer's jump conditions look at.
  typedef struct packed {
    logic adv_busy;
    logic in_xfer;
    logic last;
    logic scan_busy;
    logic emit_busy;
  } dswap_flags_t;

  // The program: a jump is taken when its condition holds, else the next step follows.
  function automatic ucode_word_t ucode_rom(step_t step);
    ucode_word_t w;
    case (step)
      STEP_ADVANCE: w = '{op: UOP_ADVANCE, cond: COND_ADV_BUSY,  target: STEP_ADVANCE};
      STEP_ACCEPT:  w = '{op: UOP_ACCEPT,  cond: COND_NO_XFER,   target: STEP_ACCEPT};
      STEP_CHECK:   w = '{op: UOP_NOP,     cond: COND_NOT_LAST,  target: STEP_EMIT};
      STEP_SCAN:    w = '{op: UOP_SCAN,    cond: COND_SCAN_BUSY, target: STEP_SCAN};
      STEP_TAIL:    w = '{op: UOP_TAIL,    cond: COND_NEVER,     target: STEP_ADVANCE};
      STEP_EMIT:    w = '{op: UOP_EMIT,    cond: COND_EMIT_BUSY, target: STEP_EMIT};
      STEP_CLOSE:   w = '{op: UOP_CLOSE,   cond: COND_ALWAYS,    target: STEP_ADVANCE};
      default:      w = '{op: UOP_NOP,     cond: COND_ALWAYS,    target: STEP_ADVANCE};
    endcase
    return w;
  endfunction

  // Descriptor byte at an index; indexes past the descriptor read as zero.
  function automatic logic [7:0] desc_byte_at(logic [127:0] desc, logic [4:0] idx);
    logic [7:0] b;
    if (idx >= 5'(DESC_BYTES) || idx[4]) begin
      b = 8'h00;
    end else begin
      b = desc[{idx[3:0], 3'b000} +: 8];
    end
    return b;
  endfunction

  function automatic logic size_ok(logic [3:0] sz);
    return (sz == 4'd1) || (sz == 4'd2) || (sz == 4'd4);
  endfunction

endpackage

>>> src/dswap_useq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dswap_useq
// Microcode sequencer: step counter, program table and jump logic.
// ----------------------------------------------------------------------------
module dswap_useq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dswap_pkg::dswap_flags_t flags,
  output dswap_pkg::uop_t       op
);
  import dswap_pkg::*;

  step_t       step_r;
  step_t       step_nxt;
  ucode_word_t word;
  logic        take;

  always_comb begin
    word = ucode_rom(step_r);
    case (word.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_ADV_BUSY:  take = flags.adv_busy;
      COND_NO_XFER:   take = !flags.in_xfer;
      COND_NOT_LAST:  take = !flags.last;
      COND_SCAN_BUSY: take = flags.scan_busy;
      COND_EMIT_BUSY: take = flags.emit_busy;
      default:        take = 1'b1;
    endcase
    step_nxt = take ? word.target : step_t'(step_r + 3'd1);
    op = word.op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_ADVANCE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // The input is only offered in the accept step.
  a_accept_step: assert property (@(posedge clk) disable iff (!rst_n)
    flags.in_xfer |-> step_r == STEP_ACCEPT)
    else $error("input transfer outside the accept step");

endmodule

>>> src/dswap_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dswap_dp
// Datapath: descriptor registers written through cfg_, plus record state,
// field buffer, output queue and output register, driven by the current op.
// ----------------------------------------------------------------------------
module dswap_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dswap_pkg::uop_t                       op,
  output dswap_pkg::dswap_flags_t               flags,
  input  logic                                  cfg_we,
  input  logic [dswap_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [dswap_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  dswap_pkg::dswap_in_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output dswap_pkg::dswap_out_t                 out_data
);
  import dswap_pkg::*;

  logic [CFG_DATA_W-1:0] desc_low_r, desc_high_r;

  logic [4:0] entry_index_r, entry_index_nxt;
  logic [3:0] fields_left_r, fields_left_nxt;
  logic [2:0] field_size_r, field_size_nxt;
  logic [7:0] held_r [3];
  logic [7:0] held_nxt [3];
  logic [1:0] held_count_r, held_count_nxt;
  logic [1:0] sticky_r, sticky_nxt;
  logic       done_r, done_nxt;

  logic       last_r, last_nxt;
  logic [4:0] scan_idx_r, scan_idx_nxt;
  logic       scan_end_r, scan_end_nxt;
  logic [1:0] tail_r, tail_nxt;

  logic [7:0] emit_q_r [4];
  logic [7:0] emit_q_nxt [4];
  logic [2:0] emit_cnt_r, emit_cnt_nxt;

  logic       out_valid_r, out_valid_nxt;
  dswap_out_t out_data_r, out_data_nxt;

  logic       in_xfer;
  logic [7:0] desc_rd;
  logic [3:0] d_cnt;
  logic [3:0] d_size;

  assign in_ready  = (op == UOP_ACCEPT);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // One read port on the descriptor, shared by the advance and tail scans.
  assign desc_rd = desc_byte_at({desc_high_r, desc_low_r},
                                (op == UOP_SCAN) ? scan_idx_r : entry_index_r);
  assign d_cnt   = (desc_rd[7:4]) & NIBBLE_MASK;
  assign d_size  = desc_rd[3:0] & NIBBLE_MASK;

  // Entries are read only once a byte is waiting, so a descriptor written
  // between bytes takes effect for every entry not yet opened.
  always_comb begin
    flags.adv_busy  = !in_valid || (!done_r && (fields_left_r == 4'd0));
    flags.in_xfer   = in_xfer;
    flags.last      = last_r;
    flags.scan_busy = !scan_end_r;
    flags.emit_busy = (emit_cnt_r != 3'd0);
  end

  always_comb begin
    entry_index_nxt = entry_index_r;
    fields_left_nxt = fields_left_r;
    field_size_nxt  = field_size_r;
    held_nxt        = held_r;
    held_count_nxt  = held_count_r;
    sticky_nxt      = sticky_r;
    done_nxt        = done_r;
    last_nxt        = last_r;
    scan_idx_nxt    = scan_idx_r;
    scan_end_nxt    = scan_end_r;
    tail_nxt        = tail_r;
    emit_q_nxt      = emit_q_r;
    emit_cnt_nxt    = emit_cnt_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;

    case (op)
      UOP_ADVANCE: begin
        if (in_valid && !done_r && fields_left_r == 4'd0) begin
          if (desc_rd == 8'h00) begin
            done_nxt = 1'b1;
          end else begin
            entry_index_nxt = entry_index_r + 5'd1;
            if (d_cnt != 4'd0) begin
              if (!size_ok(d_size)) begin
                sticky_nxt = STATUS_BAD_SIZE;
                done_nxt   = 1'b1;
              end else begin
                fields_left_nxt = d_cnt;
                field_size_nxt  = d_size[2:0];
              end
            end
          end
        end
      end
      UOP_ACCEPT: begin
        if (in_xfer) begin
          last_nxt     = in_data.last_byte;
          scan_idx_nxt = entry_index_r;
          scan_end_nxt = done_r;
          tail_nxt     = STATUS_OK;
          if (done_r) begin
            emit_q_nxt[0] = in_data.data_byte;
            emit_cnt_nxt  = 3'd1;
            if (sticky_r == STATUS_OK) begin
              sticky_nxt = STATUS_LEN_ERR;
            end
          end else if (field_size_r <= 3'd1) begin
            emit_q_nxt[0]   = in_data.data_byte;
            emit_cnt_nxt    = 3'd1;
            fields_left_nxt = fields_left_r - 4'd1;
          end else if ((3'(held_count_r) + 3'd1) < field_size_r) begin
            held_nxt[held_count_r] = in_data.data_byte;
            held_count_nxt         = held_count_r + 2'd1;
          end else begin
            // Field complete: newest byte first, then the held bytes backward.
            emit_q_nxt[0] = in_data.data_byte;
            if (field_size_r == 3'd4) begin
              emit_q_nxt[1] = held_r[2];
              emit_q_nxt[2] = held_r[1];
              emit_q_nxt[3] = held_r[0];
              emit_cnt_nxt  = 3'd4;
            end else begin
              emit_q_nxt[1] = held_r[0];
              emit_cnt_nxt  = 3'd2;
            end
            held_count_nxt  = 2'd0;
            fields_left_nxt = fields_left_r - 4'd1;
          end
        end
      end
      UOP_SCAN: begin
        if (!scan_end_r) begin
          if (desc_rd == 8'h00) begin
            scan_end_nxt = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r + 5'd1;
            if (d_cnt != 4'd0) begin
              tail_nxt     = size_ok(d_size) ? STATUS_LEN_ERR : STATUS_BAD_SIZE;
              scan_end_nxt = 1'b1;
            end
          end
        end
      end
      UOP_TAIL: begin
        if (tail_r == STATUS_BAD_SIZE) begin
          sticky_nxt = STATUS_BAD_SIZE;
        end else if ((fields_left_r != 4'd0 || held_count_r != 2'd0 ||
                      tail_r == STATUS_LEN_ERR) && sticky_r == STATUS_OK) begin
          sticky_nxt = STATUS_LEN_ERR;
        end
        // A half-filled field leaves in arrival order.
        if (held_count_r != 2'd0) begin
          emit_q_nxt[0]  = held_r[0];
          emit_q_nxt[1]  = held_r[1];
          emit_q_nxt[2]  = held_r[2];
          emit_cnt_nxt   = 3'(held_count_r);
          held_count_nxt = 2'd0;
        end
      end
      UOP_EMIT: begin
        if (emit_cnt_r != 3'd0 && (!out_valid_r || out_ready)) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.out_byte = emit_q_r[0];
          out_data_nxt.out_last = last_r && (emit_cnt_r == 3'd1);
          out_data_nxt.status   = sticky_r;
          emit_q_nxt[0]         = emit_q_r[1];
          emit_q_nxt[1]         = emit_q_r[2];
          emit_q_nxt[2]         = emit_q_r[3];
          emit_cnt_nxt          = emit_cnt_r - 3'd1;
        end
      end
      UOP_CLOSE: begin
        if (last_r) begin
          entry_index_nxt = 5'd0;
          fields_left_nxt = 4'd0;
          field_size_nxt  = 3'd0;
          held_count_nxt  = 2'd0;
          sticky_nxt      = STATUS_OK;
          done_nxt        = 1'b0;
          last_nxt        = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_low_r  <= '0;
      desc_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DESC_LOW:  desc_low_r  <= cfg_wdata;
        REG_DESC_HIGH: desc_high_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_index_r <= '0;
      fields_left_r <= '0;
      field_size_r  <= '0;
      held_count_r  <= '0;
      sticky_r      <= STATUS_OK;
      done_r        <= 1'b0;
      last_r        <= 1'b0;
      scan_idx_r    <= '0;
      scan_end_r    <= 1'b1;
      tail_r        <= STATUS_OK;
      emit_cnt_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      entry_index_r <= entry_index_nxt;
      fields_left_r <= fields_left_nxt;
      field_size_r  <= field_size_nxt;
      held_count_r  <= held_count_nxt;
      sticky_r      <= sticky_nxt;
      done_r        <= done_nxt;
      last_r        <= last_nxt;
      scan_idx_r    <= scan_idx_nxt;
      scan_end_r    <= scan_end_nxt;
      tail_r        <= tail_nxt;
      emit_cnt_r    <= emit_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r     <= held_nxt;
    emit_q_r   <= emit_q_nxt;
    out_data_r <= out_data_nxt;
  end

  a_queue_empty_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> emit_cnt_r == 3'd0)
    else $error("input offered while results are still queued");

  a_held_in_field: assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r != 2'd0 |-> !done_r && fields_left_r != 4'd0)
    else $error("bytes held outside an open field");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emit_cnt_r <= 3'd4)
    else $error("output queue overfilled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.status != 2'd3)
    else $error("undefined status code on output");

endmodule

>>> src/descriptor_endian_swapper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_endian_swapper_core
// Reverses the byte order of record fields as laid out by a descriptor.
//
// Record bytes arrive on the in_ channel (valid/ready) with a last flag on
// the final byte; converted bytes leave on the out_ channel with their own
// last flag and the record status. The descriptor is written through the
// cfg_ port (index 0: bytes 0-7, index 1: bytes 8-15); the user must write
// it while the block idles, which the block itself does not enforce.
// A short microcode program sequences the work, one step per cycle: reading
// descriptor entries (one per cycle, once a byte is waiting), taking a byte,
// scanning the remaining entries at the end of a record (one per cycle), and
// sending up to four result bytes, one per cycle while the receiver takes
// them. Results pass through an output register, so the next byte is taken
// while the last result still waits. When the receiver stalls, the queued
// results wait and no new byte is taken until they have left. Synchronous
// reset clears the descriptor, the record state and the output valid flag.
// ----------------------------------------------------------------------------
module descriptor_endian_swapper_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [dswap_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [dswap_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  dswap_pkg::dswap_in_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output dswap_pkg::dswap_out_t                 out_data
);
  import dswap_pkg::*;

  uop_t         op;
  dswap_flags_t flags;

  dswap_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op)
  );

  dswap_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .flags     (flags),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the descriptor driven byte-order swapper.
//
// A queue of record bytes feeds a clocked driver that sends them in bursts
// with random gaps. Each accepted transfer runs through a bit-accurate
// predictor of the swapper, and the expected result bytes are queued. A
// clocked monitor, with its own stall pattern on out_ready, compares every
// result transfer field by field with the oldest expected one. A directed
// section covers the corner cases of the descriptor format. It is followed
// by random descriptors, each carrying a run of records that mostly match
// the descriptor length, with short, long and random-length records mixed in.
// ----------------------------------------------------------------------------
module tb_top;
  import dswap_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_ITEMS  = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_DESC_LOW;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  dswap_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dswap_out_t out_data;

  descriptor_endian_swapper_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  dswap_in_t  record_bytes[$];
  dswap_out_t expected_bytes[$];
  int mismatches = 0;
  int cycles = 0;
  logic sender_steady = 1'b0;
  logic receiver_steady = 1'b0;

  // Predictor image of the descriptor and of the record state.
  logic [127:0] desc_img = '0;
  logic [4:0] swap_index = '0;
  logic [3:0] swap_left = '0;
  logic [3:0] swap_size = '0;
  logic [7:0] swap_held [3];
  logic [1:0] swap_held_cnt = '0;
  logic [1:0] swap_status = STATUS_OK;
  logic swap_desc_done = 1'b0;

  function automatic logic legal_size(logic [3:0] sz);
    return (sz == 4'd1) || (sz == 4'd2) || (sz == 4'd4);
  endfunction

  function automatic logic [7:0] desc_entry(int idx);
    if (idx >= DESC_BYTES) begin
      return 8'h00;
    end
    return desc_img[idx*8 +: 8];
  endfunction

  // Works out the result bytes that one accepted record byte causes.
  function automatic void predict_swap_bytes(dswap_in_t item);
    logic [7:0] emit [4];
    logic [7:0] d;
    dswap_out_t r;
    int n;
    int k;
    int idx;
    int tail;
    n = 0;
    tail = 0;

    // Open the next entry with a nonzero count, or end the descriptor.
    while (!swap_desc_done && swap_left == 0) begin
      d = desc_entry(swap_index);
      if (d == 8'h00) begin
        swap_desc_done = 1'b1;
      end else begin
        swap_index = swap_index + 1;
        if (d[7:4] != 4'd0) begin
          if (!legal_size(d[3:0])) begin
            swap_status = STATUS_BAD_SIZE;
            swap_desc_done = 1'b1;
          end else begin
            swap_left = d[7:4];
            swap_size = d[3:0];
          end
        end
      end
    end

    if (swap_desc_done) begin
      emit[n] = item.data_byte;
      n++;
      if (swap_status == STATUS_OK) swap_status = STATUS_LEN_ERR;
    end else if (swap_size <= 4'd1) begin
      emit[n] = item.data_byte;
      n++;
      swap_left = swap_left - 1;
    end else if (int'(swap_held_cnt) + 1 < int'(swap_size) && swap_held_cnt < 2'd3) begin
      swap_held[swap_held_cnt] = item.data_byte;
      swap_held_cnt = swap_held_cnt + 1;
    end else begin
      emit[n] = item.data_byte;
      n++;
      for (k = int'(swap_held_cnt); k > 0; k--) begin
        emit[n] = swap_held[k-1];
        n++;
      end
      swap_held_cnt = '0;
      swap_left = swap_left - 1;
    end

    if (item.last_byte) begin
      // The first unread entry with a nonzero count decides a short record.
      if (!swap_desc_done) begin
        for (idx = int'(swap_index); idx < DESC_BYTES; idx++) begin
          d = desc_entry(idx);
          if (d == 8'h00) break;
          if (d[7:4] != 4'd0) begin
            tail = legal_size(d[3:0]) ? 2 : 1;
            break;
          end
        end
      end
      if (tail == 1) begin
        swap_status = STATUS_BAD_SIZE;
      end else if ((swap_left != 0 || swap_held_cnt != 0 || tail == 2) &&
                   swap_status == STATUS_OK) begin
        swap_status = STATUS_LEN_ERR;
      end
      // A half-filled field leaves in arrival order.
      for (k = 0; k < int'(swap_held_cnt) && n < 4; k++) begin
        emit[n] = swap_held[k];
        n++;
      end
      swap_held_cnt = '0;
    end

    for (k = 0; k < n; k++) begin
      r.out_byte = emit[k];
      r.out_last = item.last_byte && (k == n - 1);
      r.status   = swap_status;
      expected_bytes.push_back(r);
    end

    if (item.last_byte) begin
      swap_index = '0;
      swap_left = '0;
      swap_size = '0;
      swap_held_cnt = '0;
      swap_status = STATUS_OK;
      swap_desc_done = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s: got %0h, expected %0h (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  // Sender: bursts of transfers separated by idle gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) predict_swap_bytes(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left != 0 && !sender_steady) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (record_bytes.size() != 0) begin
          in_data <= record_bytes.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a rotating stall pattern, reloaded at random whenever the tick counter wraps.
  logic [15:0] stall_pat = 16'h00ff;
  logic [5:0] stall_tick = '0;

  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick == 6'd63) begin
      stall_pat <= ($urandom_range(0, 1) != 0) ? (16'($urandom) | 16'h0001)
                                               : (16'($urandom & $urandom) | 16'h0001);
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
    end
    out_ready <= receiver_steady ? 1'b1 : stall_pat[0];
  end

  always @(posedge clk) begin : result_check
    dswap_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected result transfer", out_data.out_byte, 0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_data.out_byte, want.out_byte);
        if (out_data.out_last !== want.out_last)
          report_mismatch("out_last", out_data.out_last, want.out_last);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    dswap_in_t item;
    item.data_byte = b;
    item.last_byte = last;
    record_bytes.push_back(item);
  endtask

  // Waits until every transfer has gone out and the block has had time to finish.
  task automatic settle();
    @(posedge clk);
    while (record_bytes.size() != 0 || in_valid || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_descriptor(input logic [127:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_DESC_LOW;
    cfg_wdata <= d[63:0];
    @(posedge clk);
    cfg_addr <= REG_DESC_HIGH;
    cfg_wdata <= d[127:64];
    @(posedge clk);
    cfg_we <= 1'b0;
    desc_img = d;
  endtask

  // Record length that exactly fills the descriptor.
  function automatic int natural_len(logic [127:0] d);
    logic [7:0] e;
    int total;
    int i;
    total = 0;
    for (i = 0; i < DESC_BYTES; i++) begin
      e = d[i*8 +: 8];
      if (e == 8'h00) break;
      if (e[7:4] != 4'd0) begin
        if (!legal_size(e[3:0])) break;
        total += int'(e[7:4]) * int'(e[3:0]);
      end
    end
    return total;
  endfunction

  function automatic logic [127:0] random_descriptor();
    logic [127:0] d;
    logic [3:0] cnt;
    logic [3:0] sz;
    int entries;
    int i;
    int pick;
    d = '0;
    pick = $urandom_range(0, 11);
    if (pick == 0) return '1;
    if (pick == 1) return '0;
    entries = ($urandom_range(0, 5) == 0) ? DESC_BYTES : $urandom_range(1, 5);
    for (i = 0; i < entries; i++) begin
      pick = $urandom_range(0, 11);
      if (pick == 0) cnt = 4'd0;
      else if (pick == 1) cnt = (entries <= 5) ? 4'd15 : 4'd2;
      else cnt = 4'($urandom_range(1, 3));
      pick = $urandom_range(0, 14);
      if (pick == 0) sz = 4'($urandom_range(0, 15));
      else if (pick <= 4) sz = 4'd1;
      else if (pick <= 9) sz = 4'd2;
      else sz = 4'd4;
      d[i*8 +: 8] = {cnt, sz};
    end
    return d;
  endfunction

  initial begin : stimulus
    logic [127:0] d;
    int nat;
    int len;
    int pick;
    int i;
    int phase_items;
    int random_items;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Empty descriptor after reset: every byte is excess.
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b1);
    settle();

    // Zero-count entry skipped, then two bytes, one 16-bit and one 32-bit field.
    load_descriptor(128'h0000_0000_0000_0000_0000_0000_1412_2103);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'ha1, 1'b0);
    push_byte(8'ha2, 1'b0);
    push_byte(8'hb1, 1'b0);
    push_byte(8'hb2, 1'b0);
    push_byte(8'hb3, 1'b0);
    push_byte(8'hb4, 1'b1);
    // Short record that ends inside a 16-bit field.
    push_byte(8'h5a, 1'b0);
    push_byte(8'hc3, 1'b0);
    push_byte(8'h3c, 1'b1);
    settle();

    // Bad size after a good field; excess bytes keep the bad-size status.
    load_descriptor(128'h0000_0000_0000_0000_0000_0000_0013_0512);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0);
    push_byte(8'h44, 1'b1);
    // Short record whose first unread entry has a bad size.
    push_byte(8'h7e, 1'b1);
    settle();

    load_descriptor('1);
    push_byte(8'h80, 1'b1);
    settle();

    // Only the last descriptor slot is live; the byte after it runs off the end.
    load_descriptor({64'h1101_0101_0101_0101, 64'h0101_0101_0101_0101});
    push_byte(8'h01, 1'b0);
    push_byte(8'hfe, 1'b1);
    settle();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      d = random_descriptor();
      load_descriptor(d);
      nat = natural_len(d);
      sender_steady = ($urandom_range(0, 3) == 0);
      receiver_steady = ($urandom_range(0, 3) == 0);
      phase_items = 0;
      while (phase_items < 30) begin
        pick = $urandom_range(0, 19);
        if (nat == 0) len = $urandom_range(1, 4);
        else if (pick < 15) len = nat;
        else if (pick < 17) len = (nat > 1) ? $urandom_range(1, nat - 1) : nat + 1;
        else if (pick < 19) len = nat + $urandom_range(1, 3);
        else len = $urandom_range(1, 8);
        for (i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)), i == len - 1);
        phase_items += len;
      end
      random_items += phase_items;
      settle();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
